[sv/pwd_pkg.sv]
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared types and constants of the peer wire message deframer.
// ----------------------------------------------------------------------------
package pwd_pkg;

    // Widths fixed by the item fields
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int PIECE_CNT_W = 22;
    localparam int EVENT_W     = 3;

    // Default parameter values
    localparam int DEF_HANDSHAKE_BYTES = 68;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Message ids on the wire
    localparam logic [BYTE_W-1:0] ID_CHOKE    = 8'd0;
    localparam logic [BYTE_W-1:0] ID_UNCHOKE  = 8'd1;
    localparam logic [BYTE_W-1:0] ID_BITFIELD = 8'd5;
    localparam logic [BYTE_W-1:0] ID_PIECE    = 8'd7;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_HANDSHAKE = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CHOKE     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_UNCHOKE   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_BITFIELD  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DATA      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_EMPTY     = 3'd5;

    // One result item
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [WORD_W-1:0]  piece_num;
        logic [WORD_W-1:0]  block_begin;
        logic [BYTE_W-1:0]  data_value;
        logic               last;
        logic               choked_now;
    } res_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic in_handshake;
        logic choked;
    } front_stat_t;

endpackage

[sv/pwd_front.sv]
// ----------------------------------------------------------------------------
// pwd_front
// Byte parser: skips the handshake, deframes length-prefixed messages and
// classifies each byte into at most one result item.
// ----------------------------------------------------------------------------
module pwd_front
    import pwd_pkg::*;
#(
    parameter int HANDSHAKE_BYTES = DEF_HANDSHAKE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   restart,
    input  logic [PIECE_CNT_W-1:0] piece_count,
    output logic                   res_valid,
    output res_t                   res,
    output front_stat_t            stat
);

    localparam int HS_W = $clog2(HANDSHAKE_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HANDSHAKE,
        PH_PREFIX,
        PH_ID,
        PH_PAYLOAD
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [HS_W-1:0]     hs_cnt_reg, hs_cnt_next;
    logic [WORD_W-1:0]   len_shift_reg, len_shift_next;
    logic [1:0]          pfx_cnt_reg, pfx_cnt_next;
    logic [WORD_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0]   msg_id_reg, msg_id_next;
    logic [WORD_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]   held_index_reg, held_index_next;
    logic [WORD_W-1:0]   held_begin_reg, held_begin_next;
    logic                choke_reg, choke_next;

    logic [HS_W-1:0]     hs_inc;
    logic [WORD_W-1:0]   len_word;
    logic [WORD_W-1:0]   left_dec;
    logic                fin;
    logic [WORD_W-1:0]   pc_bytes;
    logic [BYTE_W-1:0]   bf_mask;
    logic                flag_msg;

    assign hs_inc   = hs_cnt_reg + 1'b1;
    assign len_word = {len_shift_reg[WORD_W-BYTE_W-1:0], rx_byte};
    assign left_dec = bytes_left_reg - 1'b1;
    assign fin      = (left_dec == '0);
    assign pc_bytes = WORD_W'(piece_count[PIECE_CNT_W-1:3]);

    // Bitfield mask: full bytes below piece_count/8, partial byte at it
    always_comb
    begin
        if (pos_reg < pc_bytes)
            bf_mask = 8'hFF;
        else if (pos_reg == pc_bytes)
            bf_mask = ~(8'hFF >> piece_count[2:0]);
        else
            bf_mask = '0;
    end

    // Next state and result classification
    always_comb
    begin
        phase_next      = phase_reg;
        hs_cnt_next     = hs_cnt_reg;
        len_shift_next  = len_shift_reg;
        pfx_cnt_next    = pfx_cnt_reg;
        bytes_left_next = bytes_left_reg;
        msg_id_next     = msg_id_reg;
        pos_next        = pos_reg;
        held_index_next = held_index_reg;
        held_begin_next = held_begin_reg;
        choke_next      = choke_reg;
        res_valid       = 1'b0;
        res             = '0;
        flag_msg        = 1'b0;

        if (item_valid) begin
            if (restart) begin
                phase_next     = PH_HANDSHAKE;
                hs_cnt_next    = '0;
                len_shift_next = '0;
                pfx_cnt_next   = '0;
                choke_next     = 1'b1;
            end else begin
                case (phase_reg)
                    PH_HANDSHAKE:
                    begin
                        hs_cnt_next = hs_inc;
                        if (hs_inc >= HS_W'(HANDSHAKE_BYTES)) begin
                            hs_cnt_next    = '0;
                            phase_next     = PH_PREFIX;
                            len_shift_next = '0;
                            pfx_cnt_next   = '0;
                            res_valid      = 1'b1;
                            res.event_res  = EV_HANDSHAKE;
                        end
                    end
                    PH_ID:
                    begin
                        msg_id_next     = rx_byte;
                        bytes_left_next = left_dec;
                        pos_next        = '0;
                        if (fin) begin
                            flag_msg       = 1'b1;
                            phase_next     = PH_PREFIX;
                            len_shift_next = '0;
                            pfx_cnt_next   = '0;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        bytes_left_next = left_dec;
                        pos_next        = pos_reg + 1'b1;
                        if (msg_id_reg == ID_BITFIELD) begin
                            res_valid       = 1'b1;
                            res.event_res   = EV_BITFIELD;
                            res.piece_num   = {pos_reg[WORD_W-4:0], 3'b000};
                            res.data_value  = rx_byte & bf_mask;
                            res.last        = fin;
                        end else if (msg_id_reg == ID_PIECE) begin
                            if (pos_reg[WORD_W-1:2] == '0) begin
                                held_index_next = {held_index_reg[WORD_W-BYTE_W-1:0],
                                                   rx_byte};
                            end else if (pos_reg[WORD_W-1:3] == '0) begin
                                held_begin_next = {held_begin_reg[WORD_W-BYTE_W-1:0],
                                                   rx_byte};
                                if (pos_reg[2:0] == 3'd7 && fin) begin
                                    res_valid       = 1'b1;
                                    res.event_res   = EV_EMPTY;
                                    res.piece_num   = held_index_reg;
                                    res.block_begin = held_begin_next;
                                    res.last        = 1'b1;
                                end
                            end else begin
                                res_valid       = 1'b1;
                                res.event_res   = EV_DATA;
                                res.piece_num   = held_index_reg;
                                res.block_begin = held_begin_reg;
                                res.data_value  = rx_byte;
                                res.last        = fin;
                            end
                        end else if (fin) begin
                            flag_msg = 1'b1;
                        end
                        if (fin) begin
                            phase_next     = PH_PREFIX;
                            len_shift_next = '0;
                            pfx_cnt_next   = '0;
                        end
                    end
                    default:
                    begin
                        // length prefix, big-endian
                        len_shift_next = len_word;
                        pfx_cnt_next   = pfx_cnt_reg + 1'b1;
                        if (pfx_cnt_reg == 2'd3) begin
                            if (len_word == '0) begin
                                // keep-alive
                                len_shift_next = '0;
                            end else begin
                                bytes_left_next = len_word;
                                phase_next      = PH_ID;
                            end
                        end
                    end
                endcase

                // choke / unchoke takes effect on the final message byte
                if (flag_msg) begin
                    if (msg_id_next == ID_CHOKE) begin
                        choke_next    = 1'b1;
                        res_valid     = 1'b1;
                        res.event_res = EV_CHOKE;
                    end else if (msg_id_next == ID_UNCHOKE) begin
                        choke_next    = 1'b0;
                        res_valid     = 1'b1;
                        res.event_res = EV_UNCHOKE;
                    end
                end
            end
        end
        res.choked_now = choke_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HANDSHAKE;
            hs_cnt_reg    <= '0;
            len_shift_reg <= '0;
            pfx_cnt_reg   <= '0;
            choke_reg     <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            hs_cnt_reg    <= hs_cnt_next;
            len_shift_reg <= len_shift_next;
            pfx_cnt_reg   <= pfx_cnt_next;
            choke_reg     <= choke_next;
        end
    end

    // Message payload state, always written before it is used
    always_ff @(posedge clk)
    begin
        bytes_left_reg <= bytes_left_next;
        msg_id_reg     <= msg_id_next;
        pos_reg        <= pos_next;
        held_index_reg <= held_index_next;
        held_begin_reg <= held_begin_next;
    end

    assign stat.in_handshake = (phase_reg == PH_HANDSHAKE);
    assign stat.choked       = choke_reg;

endmodule

[sv/pwd_queue.sv]
// ----------------------------------------------------------------------------
// pwd_queue
// Short result queue between the parser and the result ports.
// ----------------------------------------------------------------------------
module pwd_queue
    import pwd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  res_t                           wr_data,
    input  logic                           rd_en,
    output res_t                           rd_data,
    output logic                           empty,
    output logic                           full,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign do_rd = rd_en && (count_reg != '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign count   = count_reg;

endmodule

[sv/peer_wire_message_deframer.sv]
// ----------------------------------------------------------------------------
// peer_wire_message_deframer
// Received-byte deframer for one peer wire connection.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. The parser classifies each byte in the
// cycle it is accepted and writes at most one result into a result queue of
// QUEUE_DEPTH entries; a result is registered in a queue slot and shows on the
// result ports once it is at the head of the queue. Bytes are taken every cycle
// as long as the queue has room, so the sustained rate is one byte per clock
// while the consumer pops at that rate; full is high only while the queue holds
// QUEUE_DEPTH results. A piece_count write is taken at once and is meant for an
// idle block. There is no clearing pass after reset.
module peer_wire_message_deframer
    import pwd_pkg::*;
#(
    parameter int HANDSHAKE_BYTES = DEF_HANDSHAKE_BYTES,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [PIECE_CNT_W-1:0] cfg_data,
    // byte input
    input  logic                   push,
    output logic                   full,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   restart,
    // result output
    output logic                   empty,
    input  logic                   pop,
    output logic [EVENT_W-1:0]     event_res,
    output logic [WORD_W-1:0]      piece_num,
    output logic [WORD_W-1:0]      block_begin,
    output logic [BYTE_W-1:0]      data_value,
    output logic                   last,
    output logic                   choked_now
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PIECE_CNT_W-1:0] piece_count_reg;
    logic                   in_take;
    logic                   res_valid;
    res_t                   res;
    res_t                   head;
    front_stat_t            fstat;
    logic [CNT_W-1:0]       q_count;

    // Piece count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            piece_count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            piece_count_reg <= cfg_data;
    end

    assign in_take = push && !full;

    // Parser
    pwd_front #(
        .HANDSHAKE_BYTES(HANDSHAKE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_take),
        .rx_byte    (rx_byte),
        .restart    (restart),
        .piece_count(piece_count_reg),
        .res_valid  (res_valid),
        .res        (res),
        .stat       (fstat)
    );

    // Result queue
    pwd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_valid),
        .wr_data(res),
        .rd_en  (pop),
        .rd_data(head),
        .empty  (empty),
        .full   (full),
        .count  (q_count)
    );

    assign event_res   = head.event_res;
    assign piece_num   = head.piece_num;
    assign block_begin = head.block_begin;
    assign data_value  = head.data_value;
    assign last        = head.last;
    assign choked_now  = head.choked_now;

    // Checks
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && restart) |=> (fstat.in_handshake && fstat.choked))
        else $error("restart did not return the parser to handshake, choked");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_res <= EV_EMPTY))
        else $error("queued result has an undefined event code");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !res_valid) |=> (q_count == $past(q_count) - 1'b1))
        else $error("result queue count did not drop after a pop");

    a_no_result_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && restart) |-> !res_valid)
        else $error("restart byte produced a result");

endmodule
